/* hdl/bandwidth_counter_accumulator_assert.svh */
// Assertion macros for the bandwidth counter accumulator checker.
// No dependencies; the including file supplies the clock, reset and property.
`ifndef BANDWIDTH_COUNTER_ACCUMULATOR_ASSERT_SVH
`define BANDWIDTH_COUNTER_ACCUMULATOR_ASSERT_SVH

// Check a property outside reset.
`define BCA_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("bandwidth counter accumulator check failed");

// Check a property at every edge, reset included.
`define BCA_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("bandwidth counter accumulator check failed");

`endif

/* hdl/bca_pkg.sv */
// Shared types, codes and constants of the bandwidth counter accumulator.
// No dependencies.
package bca_pkg;

  localparam int NUM_IDS    = 1024;
  localparam int ID_W       = 10;
  localparam int ADDR_W     = $clog2(NUM_IDS);
  localparam int WORD_W     = 64;
  localparam int MUL_W      = 32;
  localparam int CORR_SHIFT = 20;
  localparam int ERR_BIT    = 63;
  localparam int UNAV_BIT   = 62;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CW_W       = 6;
  localparam int CF_W       = 21;

  typedef logic [ID_W-1:0]       id_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [1:0]            op_t;
  typedef logic [1:0]            kind_t;
  typedef logic [1:0]            status_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CW_W-1:0]       cw_t;
  typedef logic [MUL_W-1:0]      sf_t;
  typedef logic [CF_W-1:0]       cf_t;

  localparam logic [ID_W:0] ID_LIMIT = (ID_W+1)'(NUM_IDS);

  localparam op_t OP_READ      = 2'd0;
  localparam op_t OP_RESET_ONE = 2'd1;
  localparam op_t OP_RESET_ALL = 2'd2;

  localparam kind_t EV_OCC   = 2'd0;
  localparam kind_t EV_TOTAL = 2'd1;
  localparam kind_t EV_LOCAL = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_DOMAIN  = 2'd1;
  localparam status_t ST_ERR     = 2'd2;
  localparam status_t ST_UNAVAIL = 2'd3;

  localparam cfg_idx_t CFG_COUNTER_WIDTH = 3'd0;
  localparam cfg_idx_t CFG_SCALE         = 3'd1;
  localparam cfg_idx_t CFG_THRESHOLD     = 3'd2;
  localparam cfg_idx_t CFG_CORR_FACTOR   = 3'd3;
  localparam cfg_idx_t CFG_TOTAL_EN      = 3'd4;
  localparam cfg_idx_t CFG_LOCAL_EN      = 3'd5;

  localparam cf_t Q20_ONE    = CF_W'(1048576);
  localparam cw_t CW_RESET   = CW_W'(24);
  localparam sf_t SF_RESET   = MUL_W'(1);
  localparam id_t THR_RESET  = ID_W'(1023);

  typedef struct packed {
    word_t prev;
    word_t sum;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic  latch;
    logic  rd_en;
    logic  delta_en;
    logic  sum_en;
    logic  wr_reset;
    logic  clr_en;
    logic  clr_total;
    logic  clr_local;
    addr_t clr_addr;
    logic  x_raw;
    logic  x_corr;
    logic  mul_en;
    logic  mul_hi;
    logic  mul_cf;
    logic  acc_en;
    logic  acc_first;
    logic  acc_hi;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic is_bw;
    logic id_ok;
    logic fail;
    logic corr;
    logic total_en;
    logic local_en;
  } dp_stat_t;

endpackage

/* hdl/bca_in_if.sv */
// Request channel: valid/ready handshake with the request fields.
// Depends on bca_pkg.
interface bca_in_if import bca_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  id_t   monitor_id;
  kind_t event_kind;
  word_t raw_counter;
  logic  in_domain;

  modport source (output valid, output op, output monitor_id, output event_kind,
                  output raw_counter, output in_domain, input ready);
  modport sink (input valid, input op, input monitor_id, input event_kind,
                input raw_counter, input in_domain, output ready);
endinterface

/* hdl/bca_out_if.sv */
// Result channel: valid/ready handshake with status and value.
// Depends on bca_pkg.
interface bca_out_if import bca_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  word_t   value;

  modport source (output valid, output status, output value, input ready);
  modport sink (input valid, input status, input value, output ready);
endinterface

/* hdl/bandwidth_counter_accumulator.sv */
// Per-ID bandwidth accumulator, top level: sequencer plus datapath.
// Depends on bca_pkg, bca_in_if, bca_out_if, bca_ctrl, bca_datapath.
//
// One request at a time. After reset the entry RAMs are wiped, one ID per
// cycle, before in_if.ready first rises; config writes are taken during
// that time. A read that passes its checks goes through the shared 32x32
// multiplier, which forms each 64-bit product from two partial products;
// a corrected bandwidth read uses it first for the correction factor and
// then for the scale. A reset-all sweeps the entry RAMs, clearing those
// whose enable is set. The result sits in an output register, so the
// next request is taken while a finished result waits for out_if.ready.
module bandwidth_counter_accumulator import bca_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bca_in_if.sink                in_if,
  bca_out_if.source             out_if,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bca_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_if.op),
    .in_monitor_id  (in_if.monitor_id),
    .in_event_kind  (in_if.event_kind),
    .in_raw_counter (in_if.raw_counter),
    .in_in_domain   (in_if.in_domain),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_if.status),
    .out_value      (out_if.value)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

endmodule

/* hdl/bca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/bca_ctrl.sv */
// Sequencer of the bandwidth counter accumulator: clear sweeps, read-modify-write
// steps, multiply schedule and the output beat. Depends on bca_pkg.
module bca_ctrl import bca_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_DELTA = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_C0    = 4'd5;
  localparam logic [3:0] S_C1    = 4'd6;
  localparam logic [3:0] S_C2    = 4'd7;
  localparam logic [3:0] S_CX    = 4'd8;
  localparam logic [3:0] S_S0    = 4'd9;
  localparam logic [3:0] S_S1    = 4'd10;
  localparam logic [3:0] S_S2    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_WIPE  = 4'd13;

  logic [3:0] state_r, state_nxt;
  addr_t      sweep_r, sweep_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       sweep_last;

  assign sweep_last = (sweep_r == addr_t'(NUM_IDS - 1));
  assign out_valid  = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT, S_WIPE: begin
        cmd.clr_en    = 1'b1;
        cmd.clr_addr  = sweep_r;
        cmd.clr_total = (state_r == S_INIT) || stat.total_en;
        cmd.clr_local = (state_r == S_INIT) || stat.local_en;
        sweep_nxt     = sweep_r + addr_t'(1);
        if (sweep_last) begin
          sweep_nxt = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_FIN;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_FIN;
        case (stat.op)
          OP_READ: begin
            if (!stat.fail) begin
              if (stat.is_bw) begin
                state_nxt = S_DELTA;
              end else begin
                cmd.x_raw = 1'b1;
                state_nxt = S_S0;
              end
            end
          end
          OP_RESET_ONE: begin
            cmd.wr_reset = stat.is_bw && stat.id_ok;
          end
          OP_RESET_ALL: begin
            state_nxt = S_WIPE;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_DELTA: begin
        cmd.delta_en = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = stat.corr ? S_C0 : S_S0;
      end
      S_C0, S_S0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_cf = (state_r == S_C0);
        state_nxt  = (state_r == S_C0) ? S_C1 : S_S1;
      end
      S_C1, S_S1: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_hi    = 1'b1;
        cmd.mul_cf    = (state_r == S_C1);
        cmd.acc_en    = 1'b1;
        cmd.acc_first = 1'b1;
        state_nxt     = (state_r == S_C1) ? S_C2 : S_S2;
      end
      S_C2, S_S2: begin
        cmd.acc_en = 1'b1;
        cmd.acc_hi = 1'b1;
        state_nxt  = (state_r == S_C2) ? S_CX : S_FIN;
      end
      S_CX: begin
        cmd.x_corr = 1'b1;
        state_nxt  = S_S0;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/bca_datapath.sv */
// Datapath: configuration registers, per-ID entry RAMs, wrap-aware delta,
// shared 32x32 multiplier with accumulator, output register. Depends on bca_pkg, bca_ram.
module bca_datapath import bca_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  op_t       in_op,
  input  id_t       in_monitor_id,
  input  kind_t     in_event_kind,
  input  word_t     in_raw_counter,
  input  logic      in_in_domain,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output status_t   out_status,
  output word_t     out_value
);

  cw_t   cw_r;
  sf_t   sf_r;
  id_t   thr_r;
  cf_t   cf_r;
  logic  total_en_r;
  logic  local_en_r;

  op_t   op_r;
  id_t   id_r;
  kind_t kind_r;
  word_t raw_r;
  logic  dom_r;

  word_t delta_r;
  word_t x_r;
  word_t mul_r;
  word_t acc_r;
  status_t out_status_r;
  word_t   out_value_r;

  logic    is_bw;
  logic    id_ok;
  status_t rd_status;
  word_t   wmask;
  word_t   sum_new;
  entry_t  tot_rd, loc_rd, cur_rd, wr_entry;
  logic [ENTRY_W-1:0] tot_rdata, loc_rdata;
  logic    we_total, we_local;
  addr_t   waddr;
  addr_t   raddr;
  logic [MUL_W-1:0] mul_a, mul_b;
  word_t   mul_p;
  word_t   addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r       <= CW_RESET;
      sf_r       <= SF_RESET;
      thr_r      <= THR_RESET;
      cf_r       <= Q20_ONE;
      total_en_r <= 1'b1;
      local_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNTER_WIDTH: cw_r       <= cfg_wdata[CW_W-1:0];
        CFG_SCALE:         sf_r       <= cfg_wdata[MUL_W-1:0];
        CFG_THRESHOLD:     thr_r      <= cfg_wdata[ID_W-1:0];
        CFG_CORR_FACTOR:   cf_r       <= cfg_wdata[CF_W-1:0];
        CFG_TOTAL_EN:      total_en_r <= cfg_wdata[0];
        CFG_LOCAL_EN:      local_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      id_r   <= in_monitor_id;
      kind_r <= in_event_kind;
      raw_r  <= in_raw_counter;
      dom_r  <= in_in_domain;
    end
  end

  assign is_bw = (kind_r == EV_TOTAL) || (kind_r == EV_LOCAL);
  assign id_ok = ({1'b0, id_r} < ID_LIMIT);

  always_comb begin
    if (!dom_r) begin
      rd_status = ST_DOMAIN;
    end else if (raw_r[ERR_BIT]) begin
      rd_status = ST_ERR;
    end else if (raw_r[UNAV_BIT]) begin
      rd_status = ST_UNAVAIL;
    end else if (is_bw && !id_ok) begin
      rd_status = ST_UNAVAIL;
    end else begin
      rd_status = ST_OK;
    end
  end

  assign stat.op       = op_r;
  assign stat.is_bw    = is_bw;
  assign stat.id_ok    = id_ok;
  assign stat.fail     = (rd_status != ST_OK);
  assign stat.corr     = (id_r > thr_r);
  assign stat.total_en = total_en_r;
  assign stat.local_en = local_en_r;

  // Entry RAMs: one per bandwidth event, {prev, sum} per ID
  assign raddr = id_r[ADDR_W-1:0];
  assign waddr = cmd.clr_en ? cmd.clr_addr : id_r[ADDR_W-1:0];

  always_comb begin
    wr_entry = '0;
    if (cmd.sum_en) begin
      wr_entry.prev = raw_r;
      wr_entry.sum  = sum_new;
    end else if (cmd.wr_reset && !raw_r[ERR_BIT] && !raw_r[UNAV_BIT]) begin
      wr_entry.prev = raw_r;
    end
  end

  assign we_total = (cmd.clr_en && cmd.clr_total) ||
                    ((cmd.sum_en || cmd.wr_reset) && (kind_r == EV_TOTAL));
  assign we_local = (cmd.clr_en && cmd.clr_local) ||
                    ((cmd.sum_en || cmd.wr_reset) && (kind_r == EV_LOCAL));

  bca_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_IDS)) u_total_ram (
    .clk   (clk),
    .we    (we_total),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (tot_rdata)
  );

  bca_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_IDS)) u_local_ram (
    .clk   (clk),
    .we    (we_local),
    .waddr (waddr),
    .wdata (wr_entry),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (loc_rdata)
  );

  assign tot_rd = entry_t'(tot_rdata);
  assign loc_rd = entry_t'(loc_rdata);
  assign cur_rd = (kind_r == EV_LOCAL) ? loc_rd : tot_rd;

  assign wmask   = (cw_r == '0) ? '1 : ~({WORD_W{1'b1}} << cw_r);
  assign sum_new = cur_rd.sum + delta_r;

  always_ff @(posedge clk) begin
    if (cmd.delta_en) begin
      delta_r <= (raw_r - cur_rd.prev) & wmask;
    end
  end

  // Shared multiplier: one 32x32 partial product per cycle
  assign mul_a = cmd.mul_hi ? x_r[WORD_W-1:MUL_W] : x_r[MUL_W-1:0];
  assign mul_b = cmd.mul_cf ? MUL_W'(cf_r) : sf_r;
  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);
  assign addend = cmd.acc_hi ? {mul_r[MUL_W-1:0], {MUL_W{1'b0}}} : mul_r;

  always_ff @(posedge clk) begin
    if (cmd.x_raw) begin
      x_r <= raw_r;
    end else if (cmd.sum_en) begin
      x_r <= sum_new;
    end else if (cmd.x_corr) begin
      x_r <= acc_r >> CORR_SHIFT;
    end
    if (cmd.mul_en) begin
      mul_r <= mul_p;
    end
    if (cmd.acc_en) begin
      acc_r <= (cmd.acc_first ? '0 : acc_r) + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= (op_r == OP_READ) ? rd_status : ST_OK;
      out_value_r  <= ((op_r == OP_READ) && (rd_status == ST_OK)) ? acc_r : '0;
    end
  end

  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

/* hdl/bca_checker.sv */
// Port-level checks of the bandwidth counter accumulator and their binding.
// Depends on bca_pkg and bandwidth_counter_accumulator_assert.svh.
`include "bandwidth_counter_accumulator_assert.svh"

module bca_checker import bca_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_status,
  input word_t   out_value
);

  `BCA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
  `BCA_ASSERT(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK) |-> (out_value == '0))
  `BCA_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `BCA_ASSERT_ALWAYS(a_init_pass, clk, !rst_n |=> !in_ready && !out_valid)

endmodule

bind bandwidth_counter_accumulator bca_checker u_bca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.status),
  .out_value  (out_if.value)
);

/* tb/sv/testbench.sv */
// Self-checking bench for bandwidth_counter_accumulator: a directed table, then random beats
// checked against an in-bench model of the per-ID running sums across several register settings.
// Depends on bca_pkg, bca_in_if, bca_out_if and the bandwidth_counter_accumulator RTL.
module testbench import bca_pkg::*; ();

  localparam op_t   OP_UNUSED   = 2'd3;
  localparam kind_t EV_UNUSED   = 2'd3;
  localparam int    STUCK_LIMIT = 10000;
  localparam int    TAIL_CYCLES = 32;
  localparam int    PHASE_BEATS = 75;
  localparam int    NUM_HOT     = 8;
  localparam int    MAX_REPORTS = 10;

  typedef struct packed {
    op_t   op;
    id_t   mon_id;
    kind_t kind;
    word_t raw;
    logic  dom;
  } request_t;

  typedef struct packed {
    status_t status;
    word_t   value;
  } result_t;

  typedef struct packed {
    op_t     op;
    id_t     mon_id;
    kind_t   kind;
    word_t   raw;
    logic    dom;
    logic    use_table;
    status_t status;
    word_t   value;
  } directed_row_t;

  typedef struct packed {
    cw_t  cw;
    sf_t  sf;
    id_t  thr;
    cf_t  cf;
    logic total_en;
    logic local_en;
  } setting_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bca_in_if  req_ch ();
  bca_out_if rsp_ch ();

  bandwidth_counter_accumulator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cw_t   cw_reg;
  sf_t   scale_reg;
  id_t   thr_reg;
  cf_t   cf_reg;
  logic  total_en_reg;
  logic  local_en_reg;
  word_t prev_word  [2][NUM_IDS];
  word_t run_sum    [2][NUM_IDS];
  logic  entry_live [2][NUM_IDS];

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      stuck_cycles   = 0;
  int      send_pct       = 0;
  int      recv_pct       = 0;
  id_t     hot_ids   [NUM_HOT];
  word_t   hot_count [NUM_HOT][2];

  int send_pcts [4] = '{0, 45, 0, 15};
  int recv_pcts [4] = '{0, 0, 45, 15};

  setting_t phase_setting [7] = '{
    '{CW_RESET, SF_RESET, THR_RESET, Q20_ONE, 1'b1, 1'b1},
    '{6'd0, 32'hFFFF_FFFF, 10'd0, 21'h1F_FFFF, 1'b0, 1'b1},
    '{6'd63, 32'd0, 10'd512, 21'd0, 1'b1, 1'b0},
    '{6'd1, 32'd3, 10'd1023, Q20_ONE, 1'b0, 1'b0},
    '{6'd62, 32'd7, 10'd100, 21'h08_0000, 1'b1, 1'b1},
    '{6'd32, 32'd1, 10'd0, Q20_ONE, 1'b1, 1'b1},
    '{CW_RESET, SF_RESET, THR_RESET, Q20_ONE, 1'b1, 1'b1}
  };

  directed_row_t directed_rows [22] = '{
    '{OP_READ, 10'd0, EV_OCC, 64'h0, 1'b1, 1'b1, ST_OK, 64'h0},
    '{OP_READ, 10'd1023, EV_OCC, 64'h3FFF_FFFF_FFFF_FFFF, 1'b1,
      1'b1, ST_OK, 64'h3FFF_FFFF_FFFF_FFFF},
    '{OP_READ, 10'd0, EV_TOTAL, 64'h0, 1'b0, 1'b1, ST_DOMAIN, 64'h0},
    '{OP_READ, 10'd5, EV_TOTAL, 64'h8000_0000_0000_0000, 1'b1, 1'b1, ST_ERR, 64'h0},
    '{OP_READ, 10'd5, EV_LOCAL, 64'h4000_0000_0000_0000, 1'b1, 1'b1, ST_UNAVAIL, 64'h0},
    '{OP_READ, 10'd5, EV_TOTAL, 64'hC000_0000_0000_0001, 1'b1, 1'b1, ST_ERR, 64'h0},
    '{OP_READ, 10'd5, EV_TOTAL, 64'h100, 1'b1, 1'b1, ST_OK, 64'h100},
    '{OP_READ, 10'd5, EV_TOTAL, 64'h50, 1'b1, 1'b0, ST_OK, 64'h0},
    '{OP_RESET_ONE, 10'd5, EV_TOTAL, 64'h1000, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_READ, 10'd5, EV_TOTAL, 64'h1010, 1'b1, 1'b1, ST_OK, 64'h10},
    '{OP_RESET_ONE, 10'd1023, EV_LOCAL, 64'h8000_0000_0000_0123, 1'b1, 1'b1, ST_OK, 64'h0},
    '{OP_READ, 10'd1023, EV_LOCAL, 64'h200, 1'b1, 1'b1, ST_OK, 64'h200},
    '{OP_RESET_ONE, 10'd7, EV_OCC, 64'h1234, 1'b1, 1'b1, ST_OK, 64'h0},
    '{OP_UNUSED, 10'd9, EV_TOTAL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, ST_OK, 64'h0},
    '{OP_READ, 10'd9, EV_UNUSED, 64'h77, 1'b1, 1'b1, ST_OK, 64'h77},
    '{OP_READ, 10'd1023, EV_LOCAL, 64'h3FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK, 64'h0},
    '{OP_RESET_ALL, 10'd1023, EV_TOTAL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, ST_OK, 64'h0},
    '{OP_READ, 10'd5, EV_TOTAL, 64'h1020, 1'b1, 1'b1, ST_OK, 64'h1020},
    '{OP_READ, 10'd1023, EV_LOCAL, 64'h10, 1'b1, 1'b1, ST_OK, 64'h10},
    '{OP_READ, 10'd512, EV_OCC, 64'h2AAA_AAAA_AAAA_AAAA, 1'b1,
      1'b1, ST_OK, 64'h2AAA_AAAA_AAAA_AAAA},
    '{OP_READ, 10'd0, EV_TOTAL, 64'h3FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK, 64'h0},
    '{OP_READ, 10'd3, EV_OCC, 64'h4000_0000_0000_0001, 1'b1, 1'b1, ST_UNAVAIL, 64'h0}
  };

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic word_t rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic result_t predict_response(request_t r);
    result_t res;
    word_t   mask;
    word_t   acc;
    logic    bw;
    int      k;
    res.status = ST_OK;
    res.value  = '0;
    bw   = (r.kind == EV_TOTAL) || (r.kind == EV_LOCAL);
    k    = (r.kind == EV_TOTAL) ? 0 : 1;
    mask = (cw_reg == '0) ? '1 : ((word_t'(1) << cw_reg) - word_t'(1));
    case (r.op)
      OP_READ: begin
        if (!r.dom) begin
          res.status = ST_DOMAIN;
        end else if (r.raw[ERR_BIT]) begin
          res.status = ST_ERR;
        end else if (r.raw[UNAV_BIT]) begin
          res.status = ST_UNAVAIL;
        end else if (!bw) begin
          res.value = r.raw * word_t'(scale_reg);
        end else if (int'(r.mon_id) >= NUM_IDS) begin
          res.status = ST_UNAVAIL;
        end else begin
          if (!entry_live[k][r.mon_id]) begin
            prev_word[k][r.mon_id]  = '0;
            run_sum[k][r.mon_id]    = '0;
            entry_live[k][r.mon_id] = 1'b1;
          end
          run_sum[k][r.mon_id] += (r.raw - prev_word[k][r.mon_id]) & mask;
          prev_word[k][r.mon_id] = r.raw;
          acc = run_sum[k][r.mon_id];
          if (r.mon_id > thr_reg) begin
            acc = (acc * word_t'(cf_reg)) >> CORR_SHIFT;
          end
          res.value = acc * word_t'(scale_reg);
        end
      end
      OP_RESET_ONE: begin
        if (bw && (int'(r.mon_id) < NUM_IDS)) begin
          run_sum[k][r.mon_id]    = '0;
          prev_word[k][r.mon_id]  = (r.raw[ERR_BIT] || r.raw[UNAV_BIT]) ? '0 : r.raw;
          entry_live[k][r.mon_id] = 1'b1;
        end
      end
      OP_RESET_ALL: begin
        for (int i = 0; i < NUM_IDS; i++) begin
          if (total_en_reg) entry_live[0][i] = 1'b0;
          if (local_en_reg) entry_live[1][i] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic cfg_put(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_setting(setting_t s);
    cfg_put(CFG_COUNTER_WIDTH, CFG_DATA_W'(s.cw));
    cfg_put(CFG_SCALE, CFG_DATA_W'(s.sf));
    cfg_put(CFG_THRESHOLD, CFG_DATA_W'(s.thr));
    cfg_put(CFG_CORR_FACTOR, CFG_DATA_W'(s.cf));
    cfg_put(CFG_TOTAL_EN, CFG_DATA_W'(s.total_en));
    cfg_put(CFG_LOCAL_EN, CFG_DATA_W'(s.local_en));
    cfg_we       <= 1'b0;
    cw_reg       = s.cw;
    scale_reg    = s.sf;
    thr_reg      = s.thr;
    cf_reg       = s.cf;
    total_en_reg = s.total_en;
    local_en_reg = s.local_en;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic drive_request(request_t r, logic use_table, result_t table_res);
    result_t guess;
    while (roll(send_pct)) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= r.op;
    req_ch.monitor_id  <= r.mon_id;
    req_ch.event_kind  <= r.kind;
    req_ch.raw_counter <= r.raw;
    req_ch.in_domain   <= r.dom;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    guess = predict_response(r);
    pending_results.push_back(use_table ? table_res : guess);
  endtask

  function automatic request_t next_random_request();
    request_t r;
    int       h;
    int       k;
    int       pick;
    word_t    delta;
    h    = $urandom_range(0, NUM_HOT - 1);
    k    = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    r.op     = OP_READ;
    r.mon_id = hot_ids[h];
    r.kind   = k ? EV_LOCAL : EV_TOTAL;
    r.dom    = 1'b1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: delta = word_t'($urandom_range(0, 4096));
      5, 6, 7:       delta = word_t'($urandom());
      default:       delta = rand_word();
    endcase
    if (pick < 65) begin
      hot_count[h][k] = hot_count[h][k] + delta;
      r.raw = {2'b00, hot_count[h][k][61:0]};
    end else if (pick < 72) begin
      r.op  = OP_RESET_ONE;
      r.dom = 1'($urandom_range(0, 1));
      if (roll(75)) begin
        r.raw = {2'b00, hot_count[h][k][61:0]};
      end else begin
        r.raw = rand_word();
      end
    end else if (pick < 82) begin
      r.mon_id = id_t'($urandom_range(0, 1023));
      r.kind   = roll(80) ? EV_OCC : EV_UNUSED;
      r.raw    = rand_word() >> 2;
    end else if (pick < 90) begin
      r.raw = {2'b00, hot_count[h][k][61:0]};
      case ($urandom_range(0, 2))
        0:       r.dom = 1'b0;
        1:       r.raw[ERR_BIT] = 1'b1;
        default: begin
          r.raw[UNAV_BIT] = 1'b1;
          r.raw[ERR_BIT]  = 1'($urandom_range(0, 1));
        end
      endcase
    end else if (pick < 99) begin
      r.op     = op_t'($urandom_range(0, 3));
      r.mon_id = id_t'($urandom_range(0, 1023));
      r.kind   = kind_t'($urandom_range(0, 3));
      r.raw    = rand_word();
      r.dom    = 1'($urandom_range(0, 1));
    end else begin
      r.op  = OP_RESET_ALL;
      r.raw = rand_word();
      r.dom = 1'($urandom_range(0, 1));
    end
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    rsp_ch.ready <= !roll(recv_pct);
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected beat: status %0d value %h", rsp_ch.status, rsp_ch.value);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.status != rsp_ch.status || want.value != rsp_ch.value) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                     want.status, rsp_ch.status, want.value, rsp_ch.value);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    request_t r;
    result_t  table_res;
    setting_t s;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_COUNTER_WIDTH;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_READ;
    req_ch.monitor_id  = '0;
    req_ch.event_kind  = EV_OCC;
    req_ch.raw_counter = '0;
    req_ch.in_domain   = 1'b0;
    rsp_ch.ready       = 1'b0;
    for (int i = 0; i < NUM_IDS; i++) begin
      for (int k = 0; k < 2; k++) begin
        prev_word[k][i]  = '0;
        run_sum[k][i]    = '0;
        entry_live[k][i] = 1'b0;
      end
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    apply_setting(phase_setting[0]);

    foreach (directed_rows[i]) begin
      r = '{directed_rows[i].op, directed_rows[i].mon_id, directed_rows[i].kind,
            directed_rows[i].raw, directed_rows[i].dom};
      table_res = '{directed_rows[i].status, directed_rows[i].value};
      drive_request(r, directed_rows[i].use_table, table_res);
    end

    for (int p = 1; p <= 6; p++) begin
      drain_results();
      if (p == 6) begin
        phase_setting[6] = '{cw_t'($urandom_range(0, 63)), sf_t'($urandom()),
                             id_t'($urandom_range(0, 1023)),
                             cf_t'($urandom_range(0, 21'h1F_FFFF)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))};
      end
      s = phase_setting[p];
      apply_setting(s);
      send_pct = send_pcts[p % 4];
      recv_pct = recv_pcts[p % 4];
      hot_ids[0] = '0;
      hot_ids[1] = '1;
      hot_ids[2] = s.thr;
      hot_ids[3] = id_t'(s.thr + 1);
      for (int h = 4; h < NUM_HOT; h++) hot_ids[h] = id_t'($urandom_range(0, 1023));
      for (int h = 0; h < NUM_HOT; h++) begin
        hot_count[h][0] = rand_word();
        hot_count[h][1] = rand_word();
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ((p == 3 && n == 30) || roll(1)) drain_results();
        r = next_random_request();
        drive_request(r, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
